// ===== sv/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and the microcode program of the character-LCD writer.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int ROWS_DEFAULT    = 4;
	localparam int COLUMNS_DEFAULT = 20;

	// request commands
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SETPOS = 2'd1;
	localparam logic [1:0] CMD_INIT   = 2'd2;
	localparam logic [1:0] CMD_STYLE  = 2'd3;

	// control characters
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CLEAR = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] STYLE_HIDDEN    = 2'd0;
	localparam logic [1:0] STYLE_UNDERLINE = 2'd1;
	localparam logic [1:0] STYLE_BLINK     = 2'd2;

	typedef enum logic [1:0] {SRC_CURSOR, SRC_CONST, SRC_CHAR, SRC_STYLE} src_t;
	typedef enum logic [1:0] {CUR_KEEP, CUR_ADVANCE, CUR_ZERO, CUR_LOAD} cur_op_t;
	typedef enum logic [1:0] {SEQ_NEXT, SEQ_END, SEQ_GOTO, SEQ_BR_COLZ} seq_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// program entry points
	localparam upc_t UA_INIT      = 5'd0;
	localparam upc_t UA_CR        = 5'd10;
	localparam upc_t UA_LF        = 5'd11;
	localparam upc_t UA_LF_TEST   = 5'd12;
	localparam upc_t UA_LF_DONE   = 5'd14;
	localparam upc_t UA_CLEAR     = 5'd15;
	localparam upc_t UA_CHAR      = 5'd18;
	localparam upc_t UA_SETPOS    = 5'd20;
	localparam upc_t UA_STYLE     = 5'd22;
	localparam upc_t UA_STYLE_NOP = 5'd23;

	typedef struct packed {
		logic       emit;
		src_t       src;
		logic [7:0] lit;
		logic       rs;
		logic       nib;
		logic       last;
		cur_op_t    cur;
		seq_t       seq;
		upc_t       target;
	} uword_t;

	function automatic uword_t uw(logic emit, src_t src, logic [7:0] lit, logic rs,
			logic nib, logic last, cur_op_t cur, seq_t seq, upc_t target);
		uword_t w;
		w.emit   = emit;
		w.src    = src;
		w.lit    = lit;
		w.rs     = rs;
		w.nib    = nib;
		w.last   = last;
		w.cur    = cur;
		w.seq    = seq;
		w.target = target;
		return w;
	endfunction

	// control store
	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		case (pc)
			// initialize: four nibbles, then six instructions
			5'd0:  w = uw(1'b1, SRC_CONST, 8'h30, 1'b0, 1'b1, 1'b0, CUR_ZERO, SEQ_NEXT, '0);
			5'd1:  w = uw(1'b1, SRC_CONST, 8'h30, 1'b0, 1'b1, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd2:  w = uw(1'b1, SRC_CONST, 8'h30, 1'b0, 1'b1, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd3:  w = uw(1'b1, SRC_CONST, 8'h20, 1'b0, 1'b1, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd4:  w = uw(1'b1, SRC_CONST, 8'h28, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd5:  w = uw(1'b1, SRC_CONST, 8'h08, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd6:  w = uw(1'b1, SRC_CONST, 8'h0F, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd7:  w = uw(1'b1, SRC_CONST, 8'h01, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd8:  w = uw(1'b1, SRC_CONST, 8'h06, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd9:  w = uw(1'b1, SRC_CONST, 8'h02, 1'b0, 1'b0, 1'b1, CUR_KEEP, SEQ_END, '0);
			// carriage return
			5'd10: w = uw(1'b1, SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b1, CUR_KEEP, SEQ_END, '0);
			// line feed: pad with spaces until column wraps to zero
			5'd11: w = uw(1'b1, SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd12: w = uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_BR_COLZ,
					UA_LF_DONE);
			5'd13: w = uw(1'b1, SRC_CONST, CH_SPACE, 1'b1, 1'b0, 1'b0, CUR_ADVANCE, SEQ_GOTO,
					UA_LF_TEST);
			5'd14: w = uw(1'b1, SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b1, CUR_KEEP, SEQ_END, '0);
			// clear screen
			5'd15: w = uw(1'b1, SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd16: w = uw(1'b1, SRC_CONST, 8'h02, 1'b0, 1'b0, 1'b0, CUR_ZERO, SEQ_NEXT, '0);
			5'd17: w = uw(1'b1, SRC_CONST, 8'h01, 1'b0, 1'b0, 1'b1, CUR_KEEP, SEQ_END, '0);
			// printable character
			5'd18: w = uw(1'b1, SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_NEXT, '0);
			5'd19: w = uw(1'b1, SRC_CHAR, 8'h00, 1'b1, 1'b0, 1'b1, CUR_ADVANCE, SEQ_END, '0);
			// set position
			5'd20: w = uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, CUR_LOAD, SEQ_NEXT, '0);
			5'd21: w = uw(1'b1, SRC_CURSOR, 8'h00, 1'b0, 1'b0, 1'b1, CUR_KEEP, SEQ_END, '0);
			// cursor style
			5'd22: w = uw(1'b1, SRC_STYLE, 8'h00, 1'b0, 1'b0, 1'b1, CUR_KEEP, SEQ_END, '0);
			5'd23: w = uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_END, '0);
			default: w = uw(1'b0, SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, CUR_KEEP, SEQ_END, '0);
		endcase
		return w;
	endfunction

	function automatic logic [7:0] row_base(logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0:    b = 8'h80;
			2'd1:    b = 8'hC0;
			2'd2:    b = 8'h94;
			2'd3:    b = 8'hD4;
			default: b = 8'h80;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] style_cmd(logic [1:0] s);
		logic [7:0] b;
		case (s)
			STYLE_HIDDEN:    b = 8'h0C;
			STYLE_UNDERLINE: b = 8'h0E;
			STYLE_BLINK:     b = 8'h0F;
			default:         b = 8'h0C;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/char_lcd_text_writer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_text_writer_top
// Microcoded sequencer turning text requests into character-LCD transactions.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------------
//   s_*     | in  | one request: command, char, row, column, cursor style
//   m_*     | out | one LCD transaction: register select, byte, nibble flag
//
// Steps: one control word per cycle unless an emitting step stalls. A request
// is accepted, then runs its program steps: 1 to 3 steps for most requests
// (3 for clear screen), 10 for initialize, up to 2*COLUMNS+1 for a line feed
// (two steps per pad space).
// The step counter walks the control store; the request port is held off
// until the program reaches its end step.
// Stalls: a step that emits waits while the output register holds a beat
// not yet taken; a new request is taken while the last beat still waits.
// Reset: cursor at row 0, column 0, sequencer idle, no beat pending.
//
module char_lcd_text_writer_top #(
	parameter int ROWS    = clcd_pkg::ROWS_DEFAULT,
	parameter int COLUMNS = clcd_pkg::COLUMNS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // char_code[7:0], row[9:8], column[14:10],
	                              // cursor_style[16:15], zero fill
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // lcd_byte[7:0]
	output logic [1:0]  m_tuser,  // register_select[0], nibble_only[1]
	output logic        m_tlast   // last
);
	import clcd_pkg::*;

	localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int SAT_W = (COL_W > 5) ? COL_W : 5;

	// request fields
	logic [1:0] in_command;
	logic [7:0] in_char;
	logic [1:0] in_row;
	logic [4:0] in_column;
	logic [1:0] in_style;

	assign in_command = s_tuser;
	assign in_char    = s_tdata[7:0];
	assign in_row     = s_tdata[9:8];
	assign in_column  = s_tdata[14:10];
	assign in_style   = s_tdata[16:15];

	// sequencer and cursor state
	logic             busy_q;
	upc_t             upc_q;
	upc_t             upc_d;
	upc_t             entry;
	logic [1:0]       row_q;
	logic [COL_W-1:0] col_q;

	// latched request operands
	logic [7:0] char_q;
	logic [1:0] set_row_q;
	logic [4:0] set_col_q;
	logic [1:0] style_q;

	// output register
	logic       m_tvalid_q;
	logic [7:0] byte_q;
	logic       rs_q;
	logic       nib_q;
	logic       last_q;

	uword_t     uw_cur;
	logic       accept;
	logic       stall;
	logic       step;
	logic       col_zero;
	logic [7:0] emit_byte;
	logic [7:0] cursor_addr;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	assign uw_cur   = ucode(upc_q);
	// an emitting step waits for a free output register
	assign stall    = uw_cur.emit && m_tvalid_q && !m_tready;
	assign step     = busy_q && !stall;
	assign col_zero = (col_q == '0);

	assign cursor_addr = row_base(row_q) + 8'(col_q);

	// program entry by request kind
	always_comb begin
		case (in_command)
			CMD_WRITE: begin
				if (in_char == CH_CR)
					entry = UA_CR;
				else if (in_char == CH_LF)
					entry = UA_LF;
				else if (in_char == CH_CLEAR)
					entry = UA_CLEAR;
				else
					entry = UA_CHAR;
			end
			CMD_SETPOS: entry = UA_SETPOS;
			CMD_INIT:   entry = UA_INIT;
			CMD_STYLE: begin
				// style code 3 runs an empty step and emits nothing
				if (in_style == STYLE_HIDDEN || in_style == STYLE_UNDERLINE ||
						in_style == STYLE_BLINK)
					entry = UA_STYLE;
				else
					entry = UA_STYLE_NOP;
			end
			default: entry = UA_STYLE_NOP;
		endcase
	end

	// next step
	always_comb begin
		case (uw_cur.seq)
			SEQ_NEXT:    upc_d = upc_q + 1'b1;
			SEQ_GOTO:    upc_d = uw_cur.target;
			SEQ_BR_COLZ: upc_d = col_zero ? uw_cur.target : upc_q + 1'b1;
			SEQ_END:     upc_d = upc_q;
			default:     upc_d = upc_q;
		endcase
	end

	// datapath byte select
	always_comb begin
		case (uw_cur.src)
			SRC_CURSOR: emit_byte = cursor_addr;
			SRC_CONST:  emit_byte = uw_cur.lit;
			SRC_CHAR:   emit_byte = char_q;
			SRC_STYLE:  emit_byte = style_cmd(style_q);
			default:    emit_byte = uw_cur.lit;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= UA_INIT;
		end else if (accept) begin
			busy_q <= 1'b1;
			upc_q  <= entry;
		end else if (step) begin
			if (uw_cur.seq == SEQ_END)
				busy_q <= 1'b0;
			upc_q <= upc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q    <= in_char;
			set_row_q <= in_row;
			set_col_q <= in_column;
			style_q   <= in_style;
		end
	end

	// cursor updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			case (uw_cur.cur)
				CUR_ADVANCE: begin
					if (col_q == COL_W'(COLUMNS - 1)) begin
						col_q <= '0;
						row_q <= (row_q == 2'(ROWS - 1)) ? 2'd0 : row_q + 2'd1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				CUR_ZERO: begin
					row_q <= '0;
					col_q <= '0;
				end
				CUR_LOAD: begin
					row_q <= (set_row_q > 2'(ROWS - 1)) ? 2'(ROWS - 1) : set_row_q;
					col_q <= (SAT_W'(set_col_q) > SAT_W'(COLUMNS - 1)) ?
						COL_W'(COLUMNS - 1) : COL_W'(set_col_q);
				end
				CUR_KEEP: begin
					row_q <= row_q;
				end
				default: begin
					row_q <= row_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			if (step && uw_cur.emit)
				m_tvalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && uw_cur.emit) begin
			byte_q <= emit_byte;
			rs_q   <= uw_cur.rs;
			nib_q  <= uw_cur.nib;
			last_q <= uw_cur.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = {nib_q, rs_q};
	assign m_tlast  = last_q;

endmodule

// ===== sv/clcd_checker.sv =====
// ----------------------------------------------------------------------------
// clcd_checker
// Port-level checks for the character-LCD writer, bound to the top level.
// ----------------------------------------------------------------------------
module clcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed under stall");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request port open right after accept");

	// init nibbles are instructions
	a_nib_is_instr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[1] && m_tuser[0]))
		else $error("nibble transfer flagged as data");

	// nibble sits in the upper half
	a_nib_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[3:0] == 4'h0)
		else $error("nibble transfer with nonzero low bits");

endmodule

bind char_lcd_text_writer_top clcd_checker u_clcd_checker (.*);

// ===== verif/tb_char_lcd_text_writer_top.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_text_writer_top
// Self-checking bench for the character-LCD text writer.
// Requests go in through a queue-fed driver. A cursor-tracking model
// predicts every LCD beat. A monitor checks the beats in order against that
// prediction. Both sides of the stream stall at random, except in one calm
// window.
// ----------------------------------------------------------------------------
module tb_char_lcd_text_writer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import clcd_pkg::*;

	localparam int ROWS       = ROWS_DEFAULT;
	localparam int COLUMNS    = COLUMNS_DEFAULT;
	localparam int RAND_REQS  = 447;
	localparam int DRAIN_CYC  = 60;      // > longest line feed program
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT   = 24;

	// LCD instruction and nibble bytes
	localparam logic [7:0] LCD_WAKE_8BIT  = 8'h30;
	localparam logic [7:0] LCD_WAKE_4BIT  = 8'h20;
	localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
	localparam logic [7:0] LCD_DISP_OFF   = 8'h08;
	localparam logic [7:0] LCD_DISP_BLINK = 8'h0F;
	localparam logic [7:0] LCD_CLEAR      = 8'h01;
	localparam logic [7:0] LCD_ENTRY_INC  = 8'h06;
	localparam logic [7:0] LCD_HOME       = 8'h02;
	localparam logic [7:0] LCD_CUR_HIDDEN = 8'h0C;
	localparam logic [7:0] LCD_CUR_UNDER  = 8'h0E;
	localparam logic [7:0] LCD_CUR_BLINK  = 8'h0F;

	localparam logic [7:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic [1:0] row;
		logic [4:0] col;
		logic [1:0] style;
	} lcd_req_t;

	typedef struct {
		logic       rs;
		logic [7:0] data;
		logic       nib;
		logic       last;
	} lcd_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // char_code[7:0], row[9:8], column[14:10],
	                             // cursor_style[16:15], zero fill
	logic [1:0]  s_tuser = '0;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // lcd_byte[7:0]
	logic [1:0]  m_tuser;        // register_select[0], nibble_only[1]
	logic        m_tlast;        // last

	lcd_req_t  pending_reqs [$];
	lcd_beat_t lcd_expect_q [$];
	lcd_req_t  on_bus;           // request currently offered on s_*
	lcd_beat_t want;
	bit        req_taken;
	int        sent_count;
	int        total_reqs;
	int        error_count;
	int        cycle_count;

	// model copy of the cursor
	logic [1:0] cur_row;
	logic [4:0] cur_col;

	char_lcd_text_writer_top #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// cursor model and beat prediction
	// ------------------------------------------------------------------
	function automatic void queue_beat(logic rs, logic [7:0] data, logic nib);
		lcd_beat_t b;
		b.rs   = rs;
		b.data = data;
		b.nib  = nib;
		b.last = 1'b0;
		lcd_expect_q.push_back(b);
	endfunction

	function automatic void queue_cursor_addr();
		queue_beat(1'b0, ROW_ADDR[cur_row] + {3'd0, cur_col}, 1'b0);
	endfunction

	// column advance wraps into the next row, last row wraps to the top
	function automatic void advance_cursor();
		if (cur_col >= COLUMNS - 1) begin
			cur_col = '0;
			if (cur_row >= ROWS - 1)
				cur_row = '0;
			else
				cur_row = cur_row + 2'd1;
		end else begin
			cur_col = cur_col + 5'd1;
		end
	endfunction

	function automatic void predict_lcd_beats(lcd_req_t rq);
		int first;
		int guard;
		first = lcd_expect_q.size();
		case (rq.cmd)
			CMD_WRITE: begin
				// every write re-addresses the cursor first
				queue_cursor_addr();
				if (rq.ch == CH_CR) begin
					// carriage return: the address is all
				end else if (rq.ch == CH_LF) begin
					// pad the row with spaces up to the wrap
					guard = 0;
					while (cur_col != 0 && guard < COLUMNS) begin
						queue_beat(1'b1, CH_SPACE, 1'b0);
						advance_cursor();
						guard++;
					end
					queue_cursor_addr();
				end else if (rq.ch == CH_CLEAR) begin
					cur_row = '0;
					cur_col = '0;
					queue_beat(1'b0, LCD_HOME, 1'b0);
					queue_beat(1'b0, LCD_CLEAR, 1'b0);
				end else begin
					queue_beat(1'b1, rq.ch, 1'b0);
					advance_cursor();
				end
			end
			CMD_SETPOS: begin
				cur_row = (rq.row > ROWS - 1) ? 2'(ROWS - 1) : rq.row;
				cur_col = (rq.col > COLUMNS - 1) ? 5'(COLUMNS - 1) : rq.col;
				queue_cursor_addr();
			end
			CMD_INIT: begin
				cur_row = '0;
				cur_col = '0;
				queue_beat(1'b0, LCD_WAKE_8BIT, 1'b1);
				queue_beat(1'b0, LCD_WAKE_8BIT, 1'b1);
				queue_beat(1'b0, LCD_WAKE_8BIT, 1'b1);
				queue_beat(1'b0, LCD_WAKE_4BIT, 1'b1);
				queue_beat(1'b0, LCD_FUNC_SET, 1'b0);
				queue_beat(1'b0, LCD_DISP_OFF, 1'b0);
				queue_beat(1'b0, LCD_DISP_BLINK, 1'b0);
				queue_beat(1'b0, LCD_CLEAR, 1'b0);
				queue_beat(1'b0, LCD_ENTRY_INC, 1'b0);
				queue_beat(1'b0, LCD_HOME, 1'b0);
			end
			default: begin
				// style code 3 is dropped without a beat
				case (rq.style)
					STYLE_HIDDEN:    queue_beat(1'b0, LCD_CUR_HIDDEN, 1'b0);
					STYLE_UNDERLINE: queue_beat(1'b0, LCD_CUR_UNDER, 1'b0);
					STYLE_BLINK:     queue_beat(1'b0, LCD_CUR_BLINK, 1'b0);
					default: ;
				endcase
			end
		endcase
		if (lcd_expect_q.size() > first)
			lcd_expect_q[lcd_expect_q.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void add_req(logic [1:0] cmd, logic [7:0] ch, logic [1:0] row,
			logic [4:0] col, logic [1:0] style);
		lcd_req_t rq;
		rq.cmd   = cmd;
		rq.ch    = ch;
		rq.row   = row;
		rq.col   = col;
		rq.style = style;
		pending_reqs.push_back(rq);
	endfunction

	// no stalls on either side for a stretch of the random part
	function automatic bit take_break();
		bit calm;
		calm = (sent_count >= 200 && sent_count < 300);
		return !calm && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	task automatic flag_error(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// request driver: new beats go out at the falling edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		req_taken = arst_n && s_tvalid && s_tready;
		if (req_taken) begin
			predict_lcd_beats(on_bus);
			sent_count++;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !req_taken) begin
			// beat still offered, hold it
		end else if (pending_reqs.size() > 0 && !take_break()) begin
			on_bus = pending_reqs.pop_front();
			s_tdata  <= {7'd0, on_bus.style, on_bus.col, on_bus.row, on_bus.ch};
			s_tuser  <= on_bus.cmd;
			s_tvalid <= 1'b1;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// LCD side: random back-pressure and in-order beat check
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !take_break();
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (lcd_expect_q.size() == 0) begin
				flag_error($sformatf("unexpected beat byte %02h user %b last %b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = lcd_expect_q.pop_front();
				if (m_tuser[0] !== want.rs)
					flag_error($sformatf("register_select %b, want %b", m_tuser[0], want.rs));
				if (m_tdata !== want.data)
					flag_error($sformatf("lcd_byte %02h, want %02h", m_tdata, want.data));
				if (m_tuser[1] !== want.nib)
					flag_error($sformatf("nibble_only %b, want %b", m_tuser[1], want.nib));
				if (m_tlast !== want.last)
					flag_error($sformatf("last %b, want %b", m_tlast, want.last));
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("** char_lcd_text_writer_top: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int r;
		int made;
		logic [1:0] sty;
		cur_row     = '0;
		cur_col     = '0;
		sent_count  = 0;
		error_count = 0;
		cycle_count = 0;
		req_taken   = 1'b0;

		// directed: every command, field extremes, the special characters
		add_req(CMD_INIT, 8'h00, 2'd0, 5'd0, 2'd0);
		add_req(CMD_STYLE, 8'h00, 2'd0, 5'd0, STYLE_HIDDEN);
		add_req(CMD_STYLE, 8'hFF, 2'd3, 5'd31, STYLE_UNDERLINE);
		add_req(CMD_STYLE, 8'h00, 2'd0, 5'd0, STYLE_BLINK);
		add_req(CMD_STYLE, 8'h41, 2'd1, 5'd7, 2'd3);          // undefined style
		add_req(CMD_WRITE, 8'h00, 2'd0, 5'd0, 2'd0);
		add_req(CMD_WRITE, 8'hFF, 2'd3, 5'd31, 2'd3);
		add_req(CMD_WRITE, CH_CR, 2'd0, 5'd0, 2'd0);
		add_req(CMD_WRITE, CH_LF, 2'd0, 5'd0, 2'd0);          // pads the row
		add_req(CMD_WRITE, CH_LF, 2'd0, 5'd0, 2'd0);          // already at column 0
		add_req(CMD_SETPOS, 8'h00, 2'd3, 5'd31, 2'd0);        // column saturates
		add_req(CMD_WRITE, 8'h5A, 2'd0, 5'd0, 2'd0);          // wraps to the top row
		add_req(CMD_SETPOS, 8'hFF, 2'd2, 5'd19, 2'd3);
		add_req(CMD_WRITE, 8'h61, 2'd0, 5'd0, 2'd0);
		add_req(CMD_SETPOS, 8'h00, 2'd1, 5'd20, 2'd0);
		add_req(CMD_WRITE, CH_LF, 2'd0, 5'd0, 2'd0);          // one pad space
		add_req(CMD_SETPOS, 8'h00, 2'd3, 5'd1, 2'd0);
		add_req(CMD_WRITE, CH_LF, 2'd0, 5'd0, 2'd0);          // long pad, row wraps
		add_req(CMD_WRITE, 8'h7E, 2'd2, 5'd5, 2'd1);
		add_req(CMD_WRITE, CH_CLEAR, 2'd0, 5'd0, 2'd0);
		add_req(CMD_SETPOS, 8'h00, 2'd0, 5'd0, 2'd0);
		add_req(CMD_WRITE, 8'h80, 2'd0, 5'd0, 2'd0);
		add_req(CMD_INIT, 8'hFF, 2'd3, 5'd31, 2'd3);

		// random: mostly text runs with positioning, some noise
		made = 0;
		while (made < RAND_REQS) begin
			r = $urandom_range(0, 99);
			sty = 2'($urandom_range(0, 3));
			if (r < 55)
				add_req(CMD_WRITE, 8'($urandom_range(0, 255)), 2'($urandom),
					5'($urandom), sty);
			else if (r < 64)
				add_req(CMD_WRITE, CH_LF, 2'($urandom), 5'($urandom), sty);
			else if (r < 69)
				add_req(CMD_WRITE, CH_CR, 2'($urandom), 5'($urandom), sty);
			else if (r < 72)
				add_req(CMD_WRITE, CH_CLEAR, 2'($urandom), 5'($urandom), sty);
			else if (r < 86)
				add_req(CMD_SETPOS, 8'($urandom), 2'($urandom), 5'($urandom), sty);
			else if (r < 96)
				add_req(CMD_STYLE, 8'($urandom), 2'($urandom), 5'($urandom), sty);
			else
				add_req(CMD_INIT, 8'($urandom), 2'($urandom), 5'($urandom), sty);
			made++;
		end
		total_reqs = pending_reqs.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (sent_count == total_reqs);
		wait (lcd_expect_q.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);

		if (error_count == 0)
			$display("** char_lcd_text_writer_top: PASSED **");
		else
			$display("** char_lcd_text_writer_top: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/clcd_pkg.sv
sv/char_lcd_text_writer_top.sv
sv/clcd_checker.sv
verif/tb_char_lcd_text_writer_top.sv
